// ===== sv/adsr_pkg.sv =====
// Shared types and constants for the ADSR envelope and VCA block.
package adsr_pkg;

  localparam int LEVEL_BITS = 16;
  localparam int FRAC_BITS  = 15;
  localparam logic [LEVEL_BITS-1:0] FULL_SCALE = 16'h8000;

  localparam int RESET_ATTACK  = 48;
  localparam int RESET_DECAY   = 0;
  localparam int RESET_SUSTAIN = 32768;
  localparam int RESET_RELEASE = 24000;

  typedef enum logic [1:0] {
    PH_RELEASE = 2'd0,
    PH_ATTACK  = 2'd1,
    PH_DECAY   = 2'd2,
    PH_SUSTAIN = 2'd3
  } env_phase_t;

  typedef enum logic [1:0] {
    REG_ATTACK  = 2'd0,
    REG_DECAY   = 2'd1,
    REG_SUSTAIN = 2'd2,
    REG_RELEASE = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_ENV,
    ST_DIV,
    ST_VCA_LOAD,
    ST_MUL_VCA,
    ST_FINISH
  } seq_state_t;

endpackage

// ===== sv/adsr_envelope_vca.sv =====
// Linear ADSR envelope generator with VCA, bit-serial multiply and divide.
// Each item walks the sequencer states in order: attack divides, decay and live release
//   multiply then divide, sustain and silent release skip both; all then load the VCA,
//   multiply and finish (16-step shift-add multipliers, a TIME_BITS+16 step restoring divider).
// No new item is taken before the result is loaded into the output register; one is taken
//   the cycle after, even while that result waits. The load waits while a result is unaccepted.
// Reset (rst, synchronous): silent release phase, time counter and held level
//   cleared, registers back to their defaults, output register emptied.
module adsr_envelope_vca #(
  parameter int SAMPLE_BITS = 16,
  parameter int TIME_BITS   = 19
) (
  input  logic clk,
  input  logic rst,
  // input item
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]         s_tdata,   // sample_in
  input  logic [0:0]                               s_tuser,   // gate
  // result item
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  output logic [((SAMPLE_BITS+16+7)/8)*8-1:0]      m_tdata,   // sample_out, env_level
  // register writes
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [1:0]                               cfg_addr,
  input  logic [((TIME_BITS > 16) ? TIME_BITS : 16)-1:0] cfg_data
);

  localparam int LVL_W = adsr_pkg::LEVEL_BITS;
  localparam int FRAC  = adsr_pkg::FRAC_BITS;
  // dividend width: time (or time span) times a Q1.15 factor
  localparam int NUM_W = TIME_BITS + LVL_W;
  localparam int ACC_W = ((TIME_BITS > SAMPLE_BITS) ? TIME_BITS : SAMPLE_BITS) + LVL_W;
  localparam int CNT_W = $clog2(NUM_W);
  localparam int OUT_W = ((SAMPLE_BITS + 16 + 7) / 8) * 8;

  // ---------------------------------------------------------------------------
  // configuration registers; the block does not enforce it, but writes must arrive only while idle
  // ---------------------------------------------------------------------------
  logic [TIME_BITS-1:0] attack_samples;
  logic [TIME_BITS-1:0] decay_samples;
  logic [LVL_W-1:0]     sustain_level;
  logic [TIME_BITS-1:0] release_samples;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_samples  <= TIME_BITS'(adsr_pkg::RESET_ATTACK);
      decay_samples   <= TIME_BITS'(adsr_pkg::RESET_DECAY);
      sustain_level   <= LVL_W'(adsr_pkg::RESET_SUSTAIN);
      release_samples <= TIME_BITS'(adsr_pkg::RESET_RELEASE);
    end else if (cfg_valid && cfg_ready) begin
      case (adsr_pkg::cfg_reg_t'(cfg_addr))
        adsr_pkg::REG_ATTACK:  attack_samples  <= cfg_data[TIME_BITS-1:0];
        adsr_pkg::REG_DECAY:   decay_samples   <= cfg_data[TIME_BITS-1:0];
        adsr_pkg::REG_SUSTAIN: sustain_level   <= cfg_data[LVL_W-1:0];
        adsr_pkg::REG_RELEASE: release_samples <= cfg_data[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  // sustain above full scale behaves as full scale
  logic [LVL_W-1:0] sustain_sat;
  assign sustain_sat = (sustain_level > adsr_pkg::FULL_SCALE) ? adsr_pkg::FULL_SCALE
                                                              : sustain_level;

  // ---------------------------------------------------------------------------
  // envelope state and work registers
  // ---------------------------------------------------------------------------
  adsr_pkg::seq_state_t state, state_next;
  adsr_pkg::env_phase_t phase;
  logic [TIME_BITS-1:0]   time_count;
  logic [LVL_W-1:0]       held_level;
  logic                   gate_prev;

  logic [SAMPLE_BITS-1:0] sample;     // sample held for the VCA
  logic [LVL_W-1:0]       level;      // envelope level of this item
  logic [ACC_W-1:0]       acc;        // product accumulator, then dividend/quotient
  logic [ACC_W-1:0]       mcand;      // multiplicand, shifts left each step
  logic [LVL_W-1:0]       mplier;     // multiplier, shifts right each step
  logic [TIME_BITS-1:0]   rem;        // partial remainder of the divider
  logic [CNT_W-1:0]       cnt;        // steps left in the present pass

  logic [SAMPLE_BITS-1:0] out_sample;
  logic [LVL_W-1:0]       out_level;

  logic accept;
  assign s_tready = (state == adsr_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // ---------------------------------------------------------------------------
  // phase resolution for an incoming item: gate edges, then phases that
  // have run their length (a zero length drops straight through)
  // ---------------------------------------------------------------------------
  logic                 gate_in, rise, fall;
  adsr_pkg::env_phase_t ph0, ph1, ph2;
  logic [TIME_BITS-1:0] t0, t1, t2, t2_inc;
  logic                 rel_silent;

  always_comb begin
    gate_in = s_tuser[0];
    rise    = gate_in && !gate_prev;
    fall    = !gate_in && gate_prev;

    ph0 = rise ? adsr_pkg::PH_ATTACK : (fall ? adsr_pkg::PH_RELEASE : phase);
    t0  = (rise || fall) ? '0 : time_count;

    ph1 = ph0;
    t1  = t0;
    if (ph0 == adsr_pkg::PH_ATTACK && t0 >= attack_samples) begin
      ph1 = adsr_pkg::PH_DECAY;
      t1  = '0;
    end

    ph2 = ph1;
    t2  = t1;
    if (ph1 == adsr_pkg::PH_DECAY && t1 >= decay_samples) begin
      ph2 = adsr_pkg::PH_SUSTAIN;
      t2  = '0;
    end

    t2_inc     = (&t2) ? t2 : t2 + TIME_BITS'(1);
    rel_silent = (release_samples == '0) || (t2 >= release_samples);
  end

  // ---------------------------------------------------------------------------
  // serial datapath steps
  // ---------------------------------------------------------------------------
  logic [TIME_BITS-1:0] divisor;
  logic [TIME_BITS:0]   rem_sh;
  logic                 q_bit;
  logic [TIME_BITS-1:0] rem_next;
  logic [ACC_W-1:0]     div_acc_next;
  logic [ACC_W-1:0]     mul_acc_next;
  logic [LVL_W-1:0]     quot;
  logic [LVL_W-1:0]     level_div;
  logic                 neg;
  logic [SAMPLE_BITS-1:0] mag;
  logic [SAMPLE_BITS-1:0] prod_mag;

  always_comb begin
    case (phase)
      adsr_pkg::PH_ATTACK: divisor = attack_samples;
      adsr_pkg::PH_DECAY:  divisor = decay_samples;
      default:             divisor = release_samples;
    endcase

    // restoring division, one quotient bit per cycle
    rem_sh       = {rem, acc[NUM_W-1]};
    q_bit        = (rem_sh >= {1'b0, divisor});
    rem_next     = q_bit ? TIME_BITS'(rem_sh - {1'b0, divisor}) : rem_sh[TIME_BITS-1:0];
    div_acc_next = {acc[ACC_W-2:0], q_bit};
    quot         = div_acc_next[LVL_W-1:0];
    level_div    = (phase == adsr_pkg::PH_DECAY) ? adsr_pkg::FULL_SCALE - quot : quot;

    // shift-add multiply, one multiplier bit per cycle
    mul_acc_next = mplier[0] ? acc + mcand : acc;

    // VCA works on the magnitude; flooring it rounds toward zero
    neg      = sample[SAMPLE_BITS-1];
    mag      = neg ? SAMPLE_BITS'(-sample) : sample;
    prod_mag = acc[SAMPLE_BITS+FRAC-1:FRAC];
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= adsr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      adsr_pkg::ST_IDLE: begin
        if (accept) begin
          case (ph2)
            adsr_pkg::PH_ATTACK:  state_next = adsr_pkg::ST_DIV;
            adsr_pkg::PH_DECAY:   state_next = adsr_pkg::ST_MUL_ENV;
            adsr_pkg::PH_SUSTAIN: state_next = adsr_pkg::ST_VCA_LOAD;
            default: state_next = rel_silent ? adsr_pkg::ST_VCA_LOAD
                                             : adsr_pkg::ST_MUL_ENV;
          endcase
        end
      end
      adsr_pkg::ST_MUL_ENV:  if (cnt == '0) state_next = adsr_pkg::ST_DIV;
      adsr_pkg::ST_DIV:      if (cnt == '0) state_next = adsr_pkg::ST_VCA_LOAD;
      adsr_pkg::ST_VCA_LOAD: state_next = adsr_pkg::ST_MUL_VCA;
      adsr_pkg::ST_MUL_VCA:  if (cnt == '0) state_next = adsr_pkg::ST_FINISH;
      adsr_pkg::ST_FINISH:   if (!m_tvalid || m_tready) state_next = adsr_pkg::ST_IDLE;
      default:               state_next = adsr_pkg::ST_IDLE;
    endcase
  end

  // envelope state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= adsr_pkg::PH_RELEASE;
      time_count <= '0;
      held_level <= '0;
      gate_prev  <= 1'b0;
    end else begin
      if (accept) begin
        phase      <= ph2;
        time_count <= t2_inc;
        gate_prev  <= gate_in;
      end
      // the level while the note is held is where a release starts from
      if (state == adsr_pkg::ST_VCA_LOAD && phase != adsr_pkg::PH_RELEASE) begin
        held_level <= level;
      end
    end
  end

  // serial datapath
  always_ff @(posedge clk) begin
    case (state)
      adsr_pkg::ST_IDLE: begin
        if (accept) begin
          sample <= s_tdata[SAMPLE_BITS-1:0];
          rem    <= '0;
          case (ph2)
            adsr_pkg::PH_ATTACK: begin
              acc <= ACC_W'(t2) << FRAC;
              cnt <= CNT_W'(NUM_W - 1);
            end
            adsr_pkg::PH_DECAY: begin
              acc    <= '0;
              mcand  <= ACC_W'(t2);
              mplier <= adsr_pkg::FULL_SCALE - sustain_sat;
              cnt    <= CNT_W'(LVL_W - 1);
            end
            adsr_pkg::PH_SUSTAIN: begin
              level <= sustain_sat;
            end
            default: begin
              level  <= '0;
              acc    <= '0;
              mcand  <= ACC_W'(release_samples - t2);
              mplier <= held_level;
              cnt    <= CNT_W'(LVL_W - 1);
            end
          endcase
        end
      end
      adsr_pkg::ST_MUL_ENV: begin
        acc    <= mul_acc_next;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= (cnt == '0) ? CNT_W'(NUM_W - 1) : cnt - CNT_W'(1);
      end
      adsr_pkg::ST_DIV: begin
        acc <= div_acc_next;
        rem <= rem_next;
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          level <= level_div;
        end
      end
      adsr_pkg::ST_VCA_LOAD: begin
        acc    <= '0;
        mcand  <= ACC_W'(mag);
        mplier <= level;
        cnt    <= CNT_W'(LVL_W - 1);
      end
      adsr_pkg::ST_MUL_VCA: begin
        acc    <= mul_acc_next;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt - CNT_W'(1);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic load_out;
  assign load_out = (state == adsr_pkg::ST_FINISH) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sample <= neg ? SAMPLE_BITS'(-prod_mag) : prod_mag;
      out_level  <= level;
    end
  end

  assign m_tdata = OUT_W'({out_level, out_sample});

endmodule

// ===== sv/adsr_chk.sv =====
// Port-level checks for the ADSR envelope and VCA, bound to the top level.
module adsr_chk #(
  parameter int SAMPLE_BITS = 16
) (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [((SAMPLE_BITS+16+7)/8)*8-1:0] m_tdata
);

  logic [SAMPLE_BITS-1:0] samp_f;
  logic [15:0]            lvl_f;
  assign samp_f = m_tdata[SAMPLE_BITS-1:0];
  assign lvl_f  = m_tdata[SAMPLE_BITS+15:SAMPLE_BITS];

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // nothing left pending out of reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while busy");

  // envelope never above full scale
  a_level: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> lvl_f <= adsr_pkg::FULL_SCALE)
    else $error("envelope above full scale");

  // a silent envelope gives silence
  a_silent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && lvl_f == '0 |-> samp_f == '0)
    else $error("output not silent at zero level");

endmodule

bind adsr_envelope_vca adsr_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_adsr_chk (.*);

// ===== bench/tb.sv =====
// Self-checking bench for the ADSR envelope and VCA: predicts every output item and compares.
`timescale 1ns / 100ps

module tb;

  // Generous cap: several times the slowest legal run.
  localparam int CYCLE_LIMIT = 400000;

  // Output item as it sits on m_tdata: sample_out low, env_level high.
  typedef struct packed {
    logic [15:0] env_level;
    logic [15:0] sample_out;
  } vca_out_t;

  // Envelope predictor plus the queue of output items still owed by the block.
  class envelope_checker;
    logic [18:0] attack_len;
    logic [18:0] decay_len;
    logic [15:0] sustain_raw;
    logic [18:0] release_len;
    adsr_pkg::env_phase_t phase;
    logic [18:0] time_count;
    logic [15:0] held_level;
    logic        gate_prev;
    vca_out_t    owed_outputs[$];
    int          errors;

    function new();
      attack_len  = 19'(adsr_pkg::RESET_ATTACK);
      decay_len   = 19'(adsr_pkg::RESET_DECAY);
      sustain_raw = 16'(adsr_pkg::RESET_SUSTAIN);
      release_len = 19'(adsr_pkg::RESET_RELEASE);
      phase       = adsr_pkg::PH_RELEASE;
      time_count  = '0;
      held_level  = '0;
      gate_prev   = 1'b0;
      errors      = 0;
    endfunction

    function void set_reg(adsr_pkg::cfg_reg_t idx, logic [18:0] val);
      case (idx)
        adsr_pkg::REG_ATTACK:  attack_len  = val;
        adsr_pkg::REG_DECAY:   decay_len   = val;
        adsr_pkg::REG_SUSTAIN: sustain_raw = val[15:0];
        adsr_pkg::REG_RELEASE: release_len = val;
        default: ;
      endcase
    endfunction

    // Advance the envelope by one sample and return its level (Q1.15).
    function logic [15:0] next_level(logic gate);
      longint unsigned t;
      longint unsigned sus;
      longint unsigned lvl;
      if (gate && !gate_prev) begin
        phase = adsr_pkg::PH_ATTACK;
        time_count = '0;
      end else if (!gate && gate_prev) begin
        phase = adsr_pkg::PH_RELEASE;
        time_count = '0;
      end
      gate_prev = gate;

      // Phase hand-over happens before the level is worked out, so a zero
      // length phase never shows a sample of its own.
      t = time_count;
      if (phase == adsr_pkg::PH_ATTACK && t >= attack_len) begin
        phase = adsr_pkg::PH_DECAY;
        t = 0;
      end
      if (phase == adsr_pkg::PH_DECAY && t >= decay_len) begin
        phase = adsr_pkg::PH_SUSTAIN;
        t = 0;
      end
      time_count = t[18:0];

      sus = (sustain_raw > adsr_pkg::FULL_SCALE) ? adsr_pkg::FULL_SCALE : sustain_raw;
      case (phase)
        adsr_pkg::PH_ATTACK:  lvl = (t * adsr_pkg::FULL_SCALE) / attack_len;
        adsr_pkg::PH_DECAY:
          lvl = adsr_pkg::FULL_SCALE - (t * (adsr_pkg::FULL_SCALE - sus)) / decay_len;
        adsr_pkg::PH_SUSTAIN: lvl = sus;
        default: begin
          if (release_len == 0 || t >= release_len) lvl = 0;
          else lvl = (held_level * (release_len - t)) / release_len;
        end
      endcase
      if (phase != adsr_pkg::PH_RELEASE) held_level = lvl[15:0];
      if (time_count != '1) time_count = time_count + 1'b1;
      return lvl[15:0];
    endfunction

    function void note_sample(logic gate, logic [15:0] sample);
      vca_out_t    exp_out;
      logic [15:0] lvl;
      longint      prod;
      lvl  = next_level(gate);
      prod = longint'($signed(sample)) * longint'(lvl);
      // signed division truncates, i.e. rounds toward zero
      prod = prod / longint'(32768);
      exp_out.sample_out = prod[15:0];
      exp_out.env_level  = lvl;
      owed_outputs.push_back(exp_out);
    endfunction

    function int pending();
      return owed_outputs.size();
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_output(logic [31:0] data);
      vca_out_t got;
      vca_out_t exp_out;
      got = data;
      if (owed_outputs.size() == 0) begin
        report_mismatch($sformatf("unexpected output item %h", data));
      end else begin
        exp_out = owed_outputs.pop_front();
        if (got.sample_out !== exp_out.sample_out)
          report_mismatch($sformatf("sample_out %h, wanted %h (level %h)",
                                    got.sample_out, exp_out.sample_out, exp_out.env_level));
        if (got.env_level !== exp_out.env_level)
          report_mismatch($sformatf("env_level %h, wanted %h",
                                    got.env_level, exp_out.env_level));
      end
    endtask
  endclass

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = '0;   // sample_in
  logic [0:0]  s_tuser   = '0;   // gate
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;          // sample_out, env_level
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_addr  = '0;
  logic [18:0] cfg_data  = '0;

  int send_idle = 30;            // percent of cycles the sender holds off
  int recv_idle = 61;            // percent of cycles the receiver stalls
  int cycles    = 0;

  envelope_checker env_chk = new();

  adsr_envelope_vca u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: random stalls, checks each item taken. Values read here at the
  // edge are the pre-edge ones, since the block updates by NBA.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) env_chk.check_output(m_tdata);
    m_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items owed", cycles, env_chk.pending());
      $display("FAIL adsr_envelope_vca");
      $finish;
    end
  end

  // One input item. valid is only dropped during a gap, never just before
  // being raised again in the same step.
  task automatic send_item(logic gate, logic [15:0] sample);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sample;
    s_tuser  <= gate;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    env_chk.note_sample(gate, sample);
  endtask

  // Hold off the sender until every owed item has come out.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (env_chk.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(adsr_pkg::cfg_reg_t idx, logic [18:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    env_chk.set_reg(idx, val);
  endtask

  task automatic configure(logic [18:0] att, logic [18:0] dec, logic [18:0] sus,
                           logic [18:0] rel);
    drain();
    write_reg(adsr_pkg::REG_ATTACK, att);
    write_reg(adsr_pkg::REG_DECAY, dec);
    write_reg(adsr_pkg::REG_SUSTAIN, sus);
    write_reg(adsr_pkg::REG_RELEASE, rel);
    cfg_valid <= 1'b0;
  endtask

  // Mostly short ramps so every phase gets visited; now and then zero or max.
  function automatic logic [18:0] pick_length();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 19'($urandom);
      default: return 19'($urandom_range(1, 40));
    endcase
  endfunction

  // Sustain: includes values over full scale and stray bits above bit 15.
  function automatic logic [18:0] pick_sustain();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 19'(adsr_pkg::FULL_SCALE);
      2:       return 19'($urandom_range(32769, 65535));
      3:       return 19'($urandom);
      default: return 19'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Notes: gate held for a while then let go, with bursts of random gate
  // noise in between. Pauses once half way until the block is empty.
  // Exactly n_items items are sent.
  task automatic play_notes(int n_items);
    int done;
    int hold;
    int rest;
    int k;
    bit paused;
    done   = 0;
    paused = 0;
    while (done < n_items) begin
      if ($urandom_range(99) < 15) begin
        k = $urandom_range(1, 8);
        repeat (k) begin
          if (done < n_items) begin
            send_item(1'($urandom_range(1)), pick_sample());
            done++;
          end
        end
      end else begin
        hold = ($urandom_range(9) == 0) ? 1 : $urandom_range(1, 40);
        rest = ($urandom_range(9) == 0) ? 1 : $urandom_range(1, 40);
        repeat (hold) begin
          if (done < n_items) begin
            send_item(1'b1, pick_sample());
            done++;
          end
        end
        repeat (rest) begin
          if (done < n_items) begin
            send_item(1'b0, pick_sample());
            done++;
          end
        end
      end
      if (!paused && done >= n_items / 2) begin
        drain();
        paused = 1;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings. Gate high on the very first item counts as a rising
    // edge; extremes of the sample; note-up; retrigger while releasing.
    send_item(1'b1, 16'h7fff);
    send_item(1'b1, 16'h8000);
    send_item(1'b1, 16'h0000);
    send_item(1'b1, 16'hffff);
    send_item(1'b0, 16'h7fff);
    send_item(1'b0, 16'h8000);
    send_item(1'b1, 16'h1234);

    // Zero attack, decay and release; sustain above full scale is clamped.
    configure('0, '0, 19'h0ffff, '0);
    send_item(1'b1, 16'h7fff);
    send_item(1'b1, 16'h8000);
    send_item(1'b1, 16'hffff);
    send_item(1'b0, 16'h7fff);
    send_item(1'b0, 16'h8000);
    send_item(1'b1, 16'h0001);

    // Short ramps through every phase down to a zero sustain.
    configure(19'd2, 19'd3, 19'd0, 19'd1);
    repeat (7) send_item(1'b1, pick_sample());
    repeat (3) send_item(1'b0, pick_sample());

    // Random part in three idling regimes; one block with every length at max.
    for (int p = 0; p < 14; p++) begin
      if (p == 5) begin
        send_idle = 61;
        recv_idle = 30;
      end
      if (p == 10) begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (p == 4) configure('1, '1, 19'(adsr_pkg::FULL_SCALE), '1);
      else configure(pick_length(), pick_length(), pick_sustain(), pick_length());
      play_notes(60);
    end

    drain();
    repeat (60) @(posedge clk);
    if (env_chk.pending() != 0)
      env_chk.report_mismatch($sformatf("%0d output items never came", env_chk.pending()));
    if (env_chk.errors == 0) begin
      $display("PASS adsr_envelope_vca");
    end else begin
      $display("FAIL adsr_envelope_vca");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/adsr_pkg.sv
sv/adsr_envelope_vca.sv
sv/adsr_chk.sv
bench/tb.sv
